/* rtl/core/spc_pkg.sv */
// Shared constants and types of the signal pending controller.
package spc_pkg;

   localparam int QUEUE_DEPTH_DEF = 64;
   localparam int RT_CHANNELS_DEF = 16;
   localparam int INFO_BITS_DEF   = 32;

   localparam int MASK_BITS    = 64;
   localparam int WIDE_BITS    = 64;
   localparam int SIG_BITS     = 7;
   localparam int WORD_BITS    = 32;
   localparam int TSIG_BITS    = 6;
   localparam int BIT_IDX_BITS = 6;
   localparam int STD_COUNT    = 31;
   localparam int STD_POS_BITS = 5;
   localparam int CH_MAX_BITS  = 5;
   localparam int RT_FIRST     = 32;
   localparam int SIG_LIMIT    = 64;

   localparam logic OP_POST = 1'b0;
   localparam logic OP_TAKE = 1'b1;

   typedef struct packed {
      logic                    std_hit;
      logic [STD_POS_BITS-1:0] std_pos;
      logic                    rt_hit;
      logic [CH_MAX_BITS-1:0]  rt_ch;
      logic                    any;
   } pick_type;

endpackage

/* rtl/core/spc_req_if.sv */
// Request channel: operation items into the controller.
interface spc_req_if;
   import spc_pkg::*;

   logic                valid;
   logic                ready;
   logic                opcode;
   logic [SIG_BITS-1:0] sig_num;
   logic [WORD_BITS-1:0] info_word;
   logic                info_present;

   modport source (output valid, output opcode, output sig_num, output info_word,
                   output info_present, input ready);
   modport sink (input valid, input opcode, input sig_num, input info_word,
                 input info_present, output ready);
endinterface

/* rtl/core/spc_rsp_if.sv */
// Response channel: one result item per request item.
interface spc_rsp_if;
   import spc_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [TSIG_BITS-1:0] taken_signal;
   logic [WORD_BITS-1:0] taken_info;
   logic                 info_valid;
   logic                 post_stored;
   logic                 deliverable;

   modport source (output valid, output taken_signal, output taken_info, output info_valid,
                   output post_stored, output deliverable, input ready);
   modport sink (input valid, input taken_signal, input taken_info, input info_valid,
                 input post_stored, input deliverable, output ready);
endinterface

/* rtl/core/signal_pending_controller.sv */
// Top level of the signal pending controller.
// Takes one item at a time. A post or a standard take is accepted, then completes with the
// registered read of the queue pointer or standard payload memory; a realtime take also
// reads the queue payload memory after its pointer. The result sits in an output
// register; a new item is taken as soon as the previous one has left the datapath, even
// while its result waits. Pending bits and the blocked mask are flops; standard payloads,
// realtime queue payloads and queue pointers are memories. Pointer entries read as zero
// until first written, so there is no clearing pass after reset. A take delivers the lowest
// unmasked standard signal first, then the lowest unmasked non-empty realtime channel.
module signal_pending_controller #(
   parameter int QUEUE_DEPTH = spc_pkg::QUEUE_DEPTH_DEF,
   parameter int RT_CHANNELS = spc_pkg::RT_CHANNELS_DEF,
   parameter int INFO_BITS   = spc_pkg::INFO_BITS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   spc_req_if.sink                      req_chan,
   spc_rsp_if.source                    rsp_chan,
   input logic                          csr_wr_en,
   input logic [spc_pkg::MASK_BITS-1:0] csr_wr_data
);
   import spc_pkg::*;

   localparam int PW       = $clog2(2 * QUEUE_DEPTH);
   localparam int SW       = $clog2(QUEUE_DEPTH);
   localparam int CH_W     = (RT_CHANNELS > 1) ? $clog2(RT_CHANNELS) : 1;
   localparam int ST_DEPTH = RT_CHANNELS * QUEUE_DEPTH;
   localparam int SA_W     = $clog2(ST_DEPTH);
   localparam int PTR_MOD  = 2 * QUEUE_DEPTH;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RD   = 2'd1;
   localparam logic [1:0] S_DT   = 2'd2;

   localparam logic [2:0] C_NONE       = 3'd0;
   localparam logic [2:0] C_STD_POST   = 3'd1;
   localparam logic [2:0] C_RT_POST    = 3'd2;
   localparam logic [2:0] C_STD_TAKE   = 3'd3;
   localparam logic [2:0] C_RT_TAKE    = 3'd4;
   localparam logic [2:0] C_EMPTY_TAKE = 3'd5;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      r = (p == PW'(PTR_MOD - 1)) ? '0 : p + 1'b1;
      return r;
   endfunction

   function automatic logic [SW-1:0] ptr_slot(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      r = (p >= PW'(QUEUE_DEPTH)) ? p - PW'(QUEUE_DEPTH) : p;
      return r[SW-1:0];
   endfunction

   logic [1:0]              state_ff, state_in;
   logic [MASK_BITS-1:0]    mask_ff;
   logic [MASK_BITS-1:0]    pending_ff, pending_in;
   logic [RT_CHANNELS-1:0]  nonempty_ff, nonempty_in;
   logic [RT_CHANNELS-1:0]  ptr_vld_ff, ptr_vld_in;
   logic [2:0]              class_ff, acc_class;
   logic [CH_W-1:0]         ch_ff, acc_ch;
   logic [STD_POS_BITS-1:0] pos_ff, acc_pos;
   logic [BIT_IDX_BITS-1:0] bit_ff, acc_bit;
   logic                    latch_ff;
   logic [INFO_BITS-1:0]    pay_ff, acc_pay;
   logic [SA_W-1:0]         st_raddr_ff, st_raddr, st_waddr;

   logic                    rsp_valid_ff;
   logic [TSIG_BITS-1:0]    rsp_sig_ff;
   logic [WORD_BITS-1:0]    rsp_info_ff;
   logic                    rsp_ivalid_ff, rsp_stored_ff, rsp_deliv_ff;

   logic                    accept, out_free, commit;
   logic [SIG_BITS-1:0]     sig;
   logic                    sig_ok, sig_rt;
   logic [WIDE_BITS-1:0]    word_wide, info_wide;
   logic [CH_W-1:0]         ptr_raddr;
   logic [STD_POS_BITS-1:0] info_raddr;
   logic [2*PW-1:0]         ptr_rdata, ptr_word, ptr_wdata;
   logic                    ptr_we, info_we, st_we;
   logic [PW-1:0]           head, tail;
   logic [PW:0]             fill;
   logic                    full;
   logic [INFO_BITS-1:0]    info_rdata, st_rdata;
   logic [TSIG_BITS-1:0]    r_sig;
   logic [INFO_BITS-1:0]    r_info;
   logic                    r_ivalid, r_stored;
   pick_type                pick_now, pick_nxt;

   spc_pick #(.RT_CHANNELS(RT_CHANNELS)) u_pick_now (
      .pending  (pending_ff),
      .blocked  (mask_ff),
      .nonempty (nonempty_ff),
      .pick     (pick_now)
   );

   spc_pick #(.RT_CHANNELS(RT_CHANNELS)) u_pick_nxt (
      .pending  (pending_in),
      .blocked  (mask_ff),
      .nonempty (nonempty_in),
      .pick     (pick_nxt)
   );

   spc_ram #(.WIDTH(2 * PW), .DEPTH(RT_CHANNELS)) u_ptr_ram (
      .clock   (clock),
      .wr_en   (ptr_we),
      .wr_addr (ch_ff),
      .wr_data (ptr_wdata),
      .rd_addr (ptr_raddr),
      .rd_data (ptr_rdata)
   );

   spc_ram #(.WIDTH(INFO_BITS), .DEPTH(STD_COUNT)) u_info_ram (
      .clock   (clock),
      .wr_en   (info_we),
      .wr_addr (pos_ff),
      .wr_data (pay_ff),
      .rd_addr (info_raddr),
      .rd_data (info_rdata)
   );

   spc_ram #(.WIDTH(INFO_BITS), .DEPTH(ST_DEPTH)) u_store_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (pay_ff),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   // accept side
   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   assign sig       = req_chan.sig_num;
   assign sig_ok    = (sig != '0) && (sig <= SIG_BITS'(SIG_LIMIT));
   assign sig_rt    = (sig >= SIG_BITS'(RT_FIRST)) && (sig < SIG_BITS'(RT_FIRST + RT_CHANNELS));
   assign acc_bit   = BIT_IDX_BITS'(sig - 1'b1);
   assign word_wide = WIDE_BITS'(req_chan.info_word);
   assign acc_pay   = req_chan.info_present ? word_wide[INFO_BITS-1:0] : '0;

   always_comb begin
      if (req_chan.opcode == OP_TAKE) begin
         acc_ch  = pick_now.rt_ch[CH_W-1:0];
         acc_pos = pick_now.std_pos;
         if (pick_now.std_hit) begin
            acc_class = C_STD_TAKE;
         end else if (pick_now.rt_hit) begin
            acc_class = C_RT_TAKE;
         end else begin
            acc_class = C_EMPTY_TAKE;
         end
      end else begin
         acc_ch  = CH_W'(sig - SIG_BITS'(RT_FIRST));
         acc_pos = acc_bit[STD_POS_BITS-1:0];
         if (!sig_ok) begin
            acc_class = C_NONE;
         end else if (sig_rt) begin
            acc_class = C_RT_POST;
         end else begin
            acc_class = C_STD_POST;
         end
      end
   end

   assign ptr_raddr  = accept ? acc_ch : ch_ff;
   assign info_raddr = accept ? acc_pos : pos_ff;

   // queue pointers of the selected channel
   assign ptr_word = ptr_vld_ff[ch_ff] ? ptr_rdata : '0;
   assign head     = ptr_word[2*PW-1:PW];
   assign tail     = ptr_word[PW-1:0];
   assign fill     = (tail >= head) ? (PW+1)'(tail - head)
                                    : (PW+1)'(tail) + (PW+1)'(PTR_MOD) - (PW+1)'(head);
   assign full     = fill >= (PW+1)'(QUEUE_DEPTH);
   assign st_waddr = SA_W'(ch_ff) * SA_W'(QUEUE_DEPTH) + SA_W'(ptr_slot(tail));

   always_comb begin
      state_in    = state_ff;
      pending_in  = pending_ff;
      nonempty_in = nonempty_ff;
      ptr_vld_in  = ptr_vld_ff;
      ptr_we      = 1'b0;
      ptr_wdata   = {head, tail};
      info_we     = 1'b0;
      st_we       = 1'b0;
      st_raddr    = st_raddr_ff;
      commit      = 1'b0;
      r_sig       = '0;
      r_info      = '0;
      r_ivalid    = 1'b0;
      r_stored    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (class_ff == C_RT_TAKE) begin
               ptr_we             = 1'b1;
               ptr_wdata          = {ptr_inc(head), tail};
               nonempty_in[ch_ff] = (ptr_inc(head) != tail);
               st_raddr           = SA_W'(ch_ff) * SA_W'(QUEUE_DEPTH) + SA_W'(ptr_slot(head));
               state_in           = S_DT;
            end else if (out_free) begin
               commit   = 1'b1;
               state_in = S_IDLE;
               unique case (class_ff)
                  C_STD_POST: begin
                     pending_in[bit_ff] = 1'b1;
                     info_we            = latch_ff && !pending_ff[bit_ff];
                     r_stored           = 1'b1;
                  end
                  C_RT_POST: begin
                     if (!full) begin
                        st_we              = 1'b1;
                        ptr_we             = 1'b1;
                        ptr_wdata          = {head, ptr_inc(tail)};
                        nonempty_in[ch_ff] = 1'b1;
                        r_stored           = 1'b1;
                     end
                  end
                  C_STD_TAKE: begin
                     pending_in[{1'b0, pos_ff}] = 1'b0;
                     r_sig    = TSIG_BITS'(pos_ff) + 1'b1;
                     r_info   = info_rdata;
                     r_ivalid = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DT: begin
            if (out_free) begin
               commit   = 1'b1;
               state_in = S_IDLE;
               r_sig    = TSIG_BITS'(RT_FIRST) + TSIG_BITS'(ch_ff);
               r_info   = st_rdata;
               r_ivalid = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (ptr_we) begin
         ptr_vld_in[ch_ff] = 1'b1;
      end
   end

   assign info_wide = WIDE_BITS'(r_info);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mask_ff      <= '0;
         pending_ff   <= '0;
         nonempty_ff  <= '0;
         ptr_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pending_ff  <= pending_in;
         nonempty_ff <= nonempty_in;
         ptr_vld_ff  <= ptr_vld_in;
         if (csr_wr_en) begin
            mask_ff <= csr_wr_data;
         end
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      st_raddr_ff <= st_raddr;
      if (accept) begin
         class_ff <= acc_class;
         ch_ff    <= acc_ch;
         pos_ff   <= acc_pos;
         bit_ff   <= acc_bit;
         latch_ff <= (sig <= SIG_BITS'(STD_COUNT));
         pay_ff   <= acc_pay;
      end
      if (commit) begin
         rsp_sig_ff    <= r_sig;
         rsp_info_ff   <= info_wide[WORD_BITS-1:0];
         rsp_ivalid_ff <= r_ivalid;
         rsp_stored_ff <= r_stored;
         rsp_deliv_ff  <= pick_nxt.any;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.taken_signal = rsp_sig_ff;
   assign rsp_chan.taken_info   = rsp_info_ff;
   assign rsp_chan.info_valid   = rsp_ivalid_ff;
   assign rsp_chan.post_stored  = rsp_stored_ff;
   assign rsp_chan.deliverable  = rsp_deliv_ff;

   a_rt_take_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD && class_ff == C_RT_TAKE) |-> (head != tail))
      else $error("realtime take from an empty queue");

   a_std_take_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD && class_ff == C_STD_TAKE) |-> pending_ff[{1'b0, pos_ff}])
      else $error("standard take of a signal that is not pending");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD && (class_ff == C_RT_POST || class_ff == C_RT_TAKE))
      |-> (fill <= (PW+1)'(QUEUE_DEPTH)))
      else $error("queue fill level above depth");

   a_nonempty_track: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD && (class_ff == C_RT_POST || class_ff == C_RT_TAKE))
      |-> (nonempty_ff[ch_ff] == (head != tail)))
      else $error("non-empty flag disagrees with queue pointers");

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_RD && ptr_raddr == ch_ff && info_raddr == pos_ff))
      else $error("memory read address lost after accept");
endmodule

/* rtl/core/spc_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module spc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/core/spc_pick.sv */
// Priority selection of the next deliverable standard signal and realtime channel.
module spc_pick #(
   parameter int RT_CHANNELS = spc_pkg::RT_CHANNELS_DEF
) (
   input  logic [spc_pkg::MASK_BITS-1:0] pending,
   input  logic [spc_pkg::MASK_BITS-1:0] blocked,
   input  logic [RT_CHANNELS-1:0]        nonempty,
   output spc_pkg::pick_type             pick
);
   import spc_pkg::*;

   logic [STD_COUNT-1:0]   std_cand;
   logic [RT_CHANNELS-1:0] rt_cand;

   assign std_cand = pending[STD_COUNT-1:0] & ~blocked[STD_COUNT-1:0];
   assign rt_cand  = nonempty & ~blocked[RT_FIRST-1 +: RT_CHANNELS];

   always_comb begin
      pick.std_hit = |std_cand;
      pick.std_pos = '0;
      for (int i = STD_COUNT - 1; i >= 0; i--) begin
         if (std_cand[i]) begin
            pick.std_pos = STD_POS_BITS'(i);
         end
      end
      pick.rt_hit = |rt_cand;
      pick.rt_ch  = '0;
      for (int i = RT_CHANNELS - 1; i >= 0; i--) begin
         if (rt_cand[i]) begin
            pick.rt_ch = CH_MAX_BITS'(i);
         end
      end
      pick.any = pick.std_hit | pick.rt_hit;
   end
endmodule
